// ----- design/spdaf_pkg.sv -----
package spdaf_pkg;

    localparam int CHANNELS = 8;
    localparam int CHAN_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [7:0] SEMI_CHAR = 8'd59;
    localparam logic [7:0] ZERO_CHAR = 8'h30;
    localparam logic [7:0] CR_CHAR   = 8'h0d;
    localparam logic [7:0] LF_CHAR   = 8'h0a;

    localparam logic [15:0] FIVE_DIGIT_MIN = 16'd10000;

    // byte positions within one item's text
    localparam logic [3:0] SLOT_OPEN    = 4'd0;
    localparam logic [3:0] SLOT_RAW_D4  = 4'd1;
    localparam logic [3:0] SLOT_RAW_D3  = 4'd2;
    localparam logic [3:0] SLOT_RAW_D2  = 4'd3;
    localparam logic [3:0] SLOT_RAW_D1  = 4'd4;
    localparam logic [3:0] SLOT_RAW_D0  = 4'd5;
    localparam logic [3:0] SLOT_MID     = 4'd6;
    localparam logic [3:0] SLOT_BASE_D4 = 4'd7;
    localparam logic [3:0] SLOT_BASE_D3 = 4'd8;
    localparam logic [3:0] SLOT_BASE_D2 = 4'd9;
    localparam logic [3:0] SLOT_BASE_D1 = 4'd10;
    localparam logic [3:0] SLOT_BASE_D0 = 4'd11;
    localparam logic [3:0] SLOT_CLOSE   = 4'd12;
    localparam logic [3:0] SLOT_CR      = 4'd13;
    localparam logic [3:0] SLOT_LF      = 4'd14;

    typedef struct packed {
        logic [15:0] raw_value;
        logic [15:0] baseline_value;
    } item_t;

    function automatic logic [16:0] pow10(input logic [2:0] pos);
        logic [16:0] p;
        case (pos)
            3'd4:    p = 17'd10000;
            3'd3:    p = 17'd1000;
            3'd2:    p = 17'd100;
            3'd1:    p = 17'd10;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

    // decimal digit of rem at weight 10^pos; rem is below 10^(pos+1) except for pos 4
    function automatic logic [3:0] dec_digit(input logic [15:0] rem, input logic [2:0] pos);
        logic [16:0] p;
        logic [3:0]  d;
        p = pow10(pos);
        d = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({1'b0, rem} >= 17'(k) * p) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    function automatic logic [15:0] digit_weight(input logic [3:0] d, input logic [2:0] pos);
        logic [20:0] w;
        w = 21'(d) * 21'(pow10(pos));
        return w[15:0];
    endfunction

endpackage

// ----- design/spdaf_in_buf.sv -----
module spdaf_in_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_raw_value,
    input  logic [15:0]          s_baseline_value,
    output logic                 item_valid,
    input  logic                 item_ready,
    output spdaf_pkg::item_t     item
);
    import spdaf_pkg::*;

    logic  hold_valid_reg, hold_valid_next;
    item_t item_reg, item_next;

    assign s_ready    = !hold_valid_reg;
    assign item_valid = hold_valid_reg;
    assign item       = item_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        item_next       = item_reg;
        if (s_valid && s_ready) begin
            hold_valid_next          = 1'b1;
            item_next.raw_value      = s_raw_value;
            item_next.baseline_value = s_baseline_value;
        end else if (item_valid && item_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        item_reg <= item_next;
    end

endmodule

// ----- design/spdaf_emitter.sv -----
module spdaf_emitter (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    output logic             item_ready,
    input  spdaf_pkg::item_t item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_text_byte,
    output logic             m_last_of_item,
    output logic             m_end_of_record
);
    import spdaf_pkg::*;

    logic              busy_reg, busy_next;
    logic [3:0]        slot_reg, slot_next;
    logic [15:0]       num_reg, num_next;
    logic [15:0]       base_reg, base_next;
    logic              last_reg, last_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       loi_reg, loi_next;
    logic       eor_reg, eor_next;

    logic       adv;
    logic       done;
    logic [3:0] nslot;
    logic [2:0] pos;
    logic [3:0] digit;
    logic       is_digit;
    logic [7:0] cur_byte;
    logic       chan_last;

    assign adv        = !m_valid_reg || m_ready;
    assign item_ready = adv && (!busy_reg || done);
    assign chan_last  = chan_reg >= CHAN_W'(CHANNELS - 1);

    assign m_valid         = m_valid_reg;
    assign m_text_byte     = byte_reg;
    assign m_last_of_item  = loi_reg;
    assign m_end_of_record = eor_reg;

    always_comb begin
        case (slot_reg)
            SLOT_RAW_D4, SLOT_BASE_D4: pos = 3'd4;
            SLOT_RAW_D3, SLOT_BASE_D3: pos = 3'd3;
            SLOT_RAW_D2, SLOT_BASE_D2: pos = 3'd2;
            SLOT_RAW_D1, SLOT_BASE_D1: pos = 3'd1;
            SLOT_RAW_D0, SLOT_BASE_D0: pos = 3'd0;
            default:                   pos = 3'd0;
        endcase
    end

    assign digit = dec_digit(num_reg, pos);

    always_comb begin
        nslot    = slot_reg + 4'd1;
        done     = 1'b0;
        is_digit = 1'b0;
        case (slot_reg)
            SLOT_OPEN: begin
                cur_byte = SEMI_CHAR;
                nslot    = (num_reg >= FIVE_DIGIT_MIN) ? SLOT_RAW_D4 : SLOT_RAW_D3;
            end
            SLOT_MID: begin
                cur_byte = SEMI_CHAR;
                nslot    = (base_reg >= FIVE_DIGIT_MIN) ? SLOT_BASE_D4 : SLOT_BASE_D3;
            end
            SLOT_CLOSE: begin
                cur_byte = SEMI_CHAR;
                done     = !last_reg;
            end
            SLOT_CR: begin
                cur_byte = CR_CHAR;
            end
            SLOT_LF: begin
                cur_byte = LF_CHAR;
                done     = 1'b1;
            end
            default: begin
                cur_byte = ZERO_CHAR + {4'd0, digit};
                is_digit = 1'b1;
            end
        endcase
        if (!busy_reg) begin
            done = 1'b0;
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        slot_next    = slot_reg;
        num_next     = num_reg;
        base_next    = base_reg;
        last_next    = last_reg;
        chan_next    = chan_reg;
        m_valid_next = m_valid_reg;
        byte_next    = byte_reg;
        loi_next     = loi_reg;
        eor_next     = eor_reg;

        if (adv) begin
            m_valid_next = busy_reg;
            if (busy_reg) begin
                byte_next = cur_byte;
                loi_next  = done;
                eor_next  = (slot_reg == SLOT_LF);
                slot_next = nslot;
                if (is_digit) begin
                    num_next = num_reg - digit_weight(digit, pos);
                end else if (slot_reg == SLOT_MID) begin
                    num_next = base_reg;
                end
                if (done) begin
                    busy_next = 1'b0;
                end
            end
        end

        if (item_ready && item_valid) begin
            busy_next = 1'b1;
            slot_next = SLOT_OPEN;
            num_next  = item.raw_value;
            base_next = item.baseline_value;
            last_next = chan_last;
            chan_next = chan_last ? '0 : chan_reg + CHAN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            slot_reg    <= SLOT_OPEN;
            chan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            slot_reg    <= slot_next;
            chan_reg    <= chan_next;
            m_valid_reg <= m_valid_next;
        end
        num_reg  <= num_next;
        base_reg <= base_next;
        last_reg <= last_next;
        byte_reg <= byte_next;
        loi_reg  <= loi_next;
        eor_reg  <= eor_next;
    end

endmodule

// ----- design/sensor_pair_decimal_ascii_formatter_unit.sv -----
// Sensor pair text formatter.
// Input channel (s_valid/s_ready): one beat per channel reading, carrying the
// raw count and the baseline count. Output channel (m_valid/m_ready): one
// ASCII byte per beat: ';' raw ';' baseline ';', numbers in four digits with
// leading zeros, a fifth leading digit only for values of 10000 and up.
// After the last channel of a record, CR and LF follow; the LF beat carries
// m_end_of_record. The final byte of every input beat carries m_last_of_item.
// An input beat goes from the holding register to the sequencer, which
// registers each byte. Throughput: one output byte per cycle while m_ready
// is high; an item is 11 to 15 bytes (11, plus one per five-digit number,
// plus two at a record's end). The byte rate is the limit; each digit is found
// from the running remainder in the cycle the byte is produced.
// A one-entry holding register takes the next input beat while the current
// item is still being sent, so items follow with no gap.
// Reset (aresetn low, synchronous) empties both registers and restarts the
// channel count at zero. When m_ready is low, the output beat holds and the
// sequencer waits; s_ready drops once the holding register is full.
module sensor_pair_decimal_ascii_formatter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_raw_value,
    input  logic [15:0] s_baseline_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_text_byte,
    output logic        m_last_of_item,
    output logic        m_end_of_record
);
    import spdaf_pkg::*;

    logic  item_valid;
    logic  item_ready;
    item_t item;

    spdaf_in_buf u_in_buf (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_raw_value      (s_raw_value),
        .s_baseline_value (s_baseline_value),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item)
    );

    spdaf_emitter u_emitter (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_text_byte     (m_text_byte),
        .m_last_of_item  (m_last_of_item),
        .m_end_of_record (m_end_of_record)
    );

endmodule
